### src/mt_pkg.sv
`default_nettype none

package mt_pkg;

    localparam int unsigned TableN = 624;
    localparam int unsigned AddrW  = $clog2(TableN);

    typedef logic [AddrW-1:0] t_addr;
    typedef logic [31:0]      t_word;

    localparam t_addr TABLE_LAST   = t_addr'(TableN - 1);
    localparam t_addr SHIFT_M      = t_addr'(397);
    localparam t_addr SPLIT_NM     = t_addr'(227);
    localparam t_addr POS_USED_UP  = t_addr'(TableN);
    localparam t_addr POS_NEVER    = t_addr'(TableN + 1);

    localparam t_word       DEFAULT_SEED = 32'h0000_0985;
    localparam logic [16:0] LCG_MUL      = 17'h10DCD;
    localparam t_word       MATRIX_A     = 32'h9908_B0DF;
    localparam t_word       TEMPER_B     = 32'hFF3A_58AD;
    localparam t_word       TEMPER_C     = 32'hFFFF_DF8C;

    localparam logic CMD_DRAW   = 1'b0;
    localparam logic CMD_RESEED = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_TW_PRE,
        ST_TW_RD,
        ST_TW_WR,
        ST_RD,
        ST_TEMPER
    } t_state;

endpackage

`default_nettype wire

### src/mt19937_generator.sv
// Channel   | Signals                      | Direction | Handshake
// ----------+------------------------------+-----------+---------------------------------
// command   | i_cmd, i_seed                | in        | beat taken when start && !busy
// result    | o_value                      | out       | o_valid strobe, one cycle, no stall
//
// A reseed keeps the block busy while it fills the table: two LCG steps per table word through
// the single 32x17 multiplier, each word written in its second step.
// A draw from a live table passes through the table read and the temper state before the
// result strobe. Every 624th draw first twists the table: after a priming read of word 0,
// for each word ST_TW_RD reads two words over the two memory read ports and ST_TW_WR
// writes the twisted word back. The first draw after reset also fills the table
// with the default seed first. Reset is synchronous and active low; it marks the table
// as never seeded. The receiver cannot stall the result strobe.

`default_nettype none

module mt19937_generator (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire logic          i_cmd,
    input  wire mt_pkg::t_word i_seed,
    output logic               o_valid,
    output mt_pkg::t_word      o_value
);
    import mt_pkg::*;

    // Tempering: masks are applied before the shifts, same result as the usual form.
    function automatic t_word temper(input t_word y_in);
        t_word y;
        y = y_in;
        y = y ^ (y >> 11);
        y = y ^ ((y & TEMPER_B) << 7);
        y = y ^ ((y & TEMPER_C) << 15);
        y = y ^ (y >> 18);
        return y;
    endfunction

    // Control state.
    t_state r_state, n_state;
    t_addr  r_pos,   n_pos;     // next word to read; two codes above the table mean
                                // "used up" and "never seeded"
    t_addr  r_k,     n_k;       // word counter shared by fill and twist
    logic   r_ph,    n_ph;      // fill phase: first or second LCG step of a word
    logic   r_draw,  n_draw;    // a draw is waiting behind the current fill
    logic   r_valid, n_valid;

    // Datapath registers.
    t_word          r_s,     n_s;      // LCG state
    logic [15:0]    r_hi,    n_hi;     // upper half of the word being filled
    t_word          r_cur,   n_cur;    // old value of the word being twisted
    t_word          r_value, n_value;

    // Table memory: one write port, two registered read ports.
    t_word mem [TableN];
    t_word r_rd_a, r_rd_b;
    logic  w_we, w_re_a, w_re_b;
    t_addr w_waddr, w_raddr_a, w_raddr_b;
    t_word w_wdata;

    // The one multiplier of the block, used once per fill cycle.
    logic [48:0] w_prod;
    t_word       w_lcg;
    t_word       w_twist_y;
    t_word       w_twist;
    logic        w_accept;

    assign w_prod = r_s * LCG_MUL;
    assign w_lcg  = w_prod[31:0] + 32'd1;

    // Twist of word k: upper bit of the old word k, lower bits of word k+1, mixed with
    // the word 397 places ahead (mod 624).
    assign w_twist_y = {r_cur[31], r_rd_a[30:0]};
    assign w_twist   = (w_twist_y >> 1) ^ r_rd_b ^ (w_twist_y[0] ? MATRIX_A : '0);

    assign w_accept = start && !busy;
    assign busy     = (r_state != ST_IDLE);
    assign o_valid  = r_valid;
    assign o_value  = r_value;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        if (w_re_a) begin
            r_rd_a <= mem[w_raddr_a];
        end
        if (w_re_b) begin
            r_rd_b <= mem[w_raddr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pos   <= POS_NEVER;
            r_k     <= '0;
            r_ph    <= 1'b0;
            r_draw  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_k     <= n_k;
            r_ph    <= n_ph;
            r_draw  <= n_draw;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s     <= n_s;
        r_hi    <= n_hi;
        r_cur   <= n_cur;
        r_value <= n_value;
    end

    always_comb begin
        n_state   = r_state;
        n_pos     = r_pos;
        n_k       = r_k;
        n_ph      = r_ph;
        n_draw    = r_draw;
        n_valid   = 1'b0;
        n_s       = r_s;
        n_hi      = r_hi;
        n_cur     = r_cur;
        n_value   = r_value;
        w_we      = 1'b0;
        w_waddr   = r_k;
        w_wdata   = w_twist;
        w_re_a    = 1'b0;
        w_re_b    = 1'b0;
        w_raddr_a = r_pos;
        w_raddr_b = r_k;

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_k  = '0;
                    n_ph = 1'b0;
                    if (i_cmd == CMD_RESEED) begin
                        n_s     = i_seed;
                        n_draw  = 1'b0;
                        n_state = ST_FILL;
                    end else if (r_pos == POS_NEVER) begin
                        n_s     = DEFAULT_SEED;
                        n_draw  = 1'b1;
                        n_state = ST_FILL;
                    end else if (r_pos == POS_USED_UP) begin
                        n_state = ST_TW_PRE;
                    end else begin
                        n_state = ST_RD;
                    end
                end
            end

            ST_FILL: begin
                n_s = w_lcg;
                if (!r_ph) begin
                    n_hi = r_s[31:16];
                    n_ph = 1'b1;
                end else begin
                    w_we    = 1'b1;
                    w_wdata = {r_hi, r_s[31:16]};
                    n_ph    = 1'b0;
                    if (r_k == TABLE_LAST) begin
                        n_k     = '0;
                        n_pos   = POS_USED_UP;
                        n_state = r_draw ? ST_TW_PRE : ST_IDLE;
                    end else begin
                        n_k = r_k + t_addr'(1);
                    end
                end
            end

            ST_TW_PRE: begin
                // Prime the pipeline with the old word 0.
                w_re_a    = 1'b1;
                w_raddr_a = '0;
                n_k       = '0;
                n_state   = ST_TW_RD;
            end

            ST_TW_RD: begin
                // Port A holds the old word k, read as the neighbor of the previous word.
                n_cur     = r_rd_a;
                w_re_a    = 1'b1;
                w_raddr_a = (r_k == TABLE_LAST) ? t_addr'(0) : r_k + t_addr'(1);
                w_re_b    = 1'b1;
                w_raddr_b = (r_k < SPLIT_NM) ? r_k + SHIFT_M : r_k - SPLIT_NM;
                n_state   = ST_TW_WR;
            end

            ST_TW_WR: begin
                w_we    = 1'b1;
                w_wdata = w_twist;
                if (r_k == TABLE_LAST) begin
                    n_k     = '0;
                    n_pos   = '0;
                    n_draw  = 1'b0;
                    n_state = ST_RD;
                end else begin
                    n_k     = r_k + t_addr'(1);
                    n_state = ST_TW_RD;
                end
            end

            ST_RD: begin
                w_re_a    = 1'b1;
                w_raddr_a = r_pos;
                n_pos     = r_pos + t_addr'(1);
                n_state   = ST_TEMPER;
            end

            ST_TEMPER: begin
                n_value = temper(r_rd_a);
                n_valid = 1'b1;
                n_state = ST_IDLE;
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### src/mt_check.sv
`default_nettype none

module mt_check (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          start,
    input wire logic          busy,
    input wire logic          i_cmd,
    input wire mt_pkg::t_word i_seed,
    input wire logic          o_valid,
    input wire mt_pkg::t_word o_value
);
    import mt_pkg::*;

    logic w_accept;
    assign w_accept = start && !busy;

    // Reset leaves the block idle with no result pending.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !busy && !o_valid)
        else $error("block not idle after reset");

    // Every accepted beat occupies the block in the following cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> busy && !o_valid)
        else $error("accepted beat did not start work");

    // Results are strobed for one cycle only, never back to back.
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe lasted more than one cycle");

    // A result appears only when the block has finished its work.
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobed while busy");

    // A reseed beat yields no result strobe early in its table fill; a draw's result follows its read and temper.
    a_reseed_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_cmd == CMD_RESEED) |=> ##1 !o_valid)
        else $error("reseed produced a result");

endmodule

bind mt19937_generator mt_check u_mt_check (.*);

`default_nettype wire
